@@ sv/dsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// dsfe_pkg
// shared types, constants and the frame builder for the four-channel
// dshot frame encoder
// ----------------------------------------------------------------------------
package dsfe_pkg;

	localparam int unsigned NUM_CH     = 4;
	localparam int unsigned FRAME_BITS = 16;

	localparam logic [9:0]  THROTTLE_MAX    = 10'd1000;
	localparam logic [10:0] THROTTLE_OFFSET = 11'd47;

	localparam logic [9:0] HIGH_TIME_ONE_RST  = 10'd205;
	localparam logic [9:0] HIGH_TIME_ZERO_RST = 10'd102;

	// register indexes on the configuration port
	typedef enum logic [0:0] {
		REG_HIGH_TIME_ONE  = 1'b0,
		REG_HIGH_TIME_ZERO = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [9:0] throttle_ch0;
		logic [9:0] throttle_ch1;
		logic [9:0] throttle_ch2;
		logic [9:0] throttle_ch3;
		logic       telemetry_request;
	} in_item_t;

	typedef struct packed {
		logic [5:0] slot_number;
		logic [9:0] width_ch0;
		logic [9:0] width_ch1;
		logic [9:0] width_ch2;
		logic [9:0] width_ch3;
		logic       guard_slot;
		logic       last_slot;
	} out_item_t;

	// one 16-bit frame per channel
	typedef logic [NUM_CH-1:0][FRAME_BITS-1:0] frame_set_t;

	// saturate, map to 2t+47, append telemetry bit and nibble checksum
	function automatic logic [15:0] make_frame(input logic [9:0] throttle,
		input logic telem);
		logic [9:0]  t;
		logic [10:0] v;
		logic [11:0] word;
		logic [3:0]  csum;
		t    = (throttle > THROTTLE_MAX) ? THROTTLE_MAX : throttle;
		v    = {t, 1'b0} + THROTTLE_OFFSET;
		word = {v, telem};
		csum = word[3:0] ^ word[7:4] ^ word[11:8];
		return {word, csum};
	endfunction

endpackage

@@ sv/dsfe_front.sv @@
// ----------------------------------------------------------------------------
// dsfe_front
// takes in throttle beats and builds the four channel frames into a
// single pipeline register ahead of the frame queue
// ----------------------------------------------------------------------------
module dsfe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  dsfe_pkg::in_item_t    item,
	output logic                  frm_valid,
	input  logic                  frm_ready,
	output dsfe_pkg::frame_set_t  frm_data
);

	logic                 valid_s1;
	dsfe_pkg::frame_set_t frame_s1;
	logic                 stage_load;

	// the stage can take a new beat when empty or when it drains this cycle
	assign stage_load = !valid_s1 || frm_ready;
	assign full       = !stage_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stage_load) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_load && push) begin
			frame_s1[0] <= dsfe_pkg::make_frame(item.throttle_ch0, item.telemetry_request);
			frame_s1[1] <= dsfe_pkg::make_frame(item.throttle_ch1, item.telemetry_request);
			frame_s1[2] <= dsfe_pkg::make_frame(item.throttle_ch2, item.telemetry_request);
			frame_s1[3] <= dsfe_pkg::make_frame(item.throttle_ch3, item.telemetry_request);
		end
	end

	assign frm_valid = valid_s1;
	assign frm_data  = frame_s1;

endmodule

@@ sv/dsfe_queue.sv @@
// ----------------------------------------------------------------------------
// dsfe_queue
// two-entry frame queue between front and back
// ----------------------------------------------------------------------------
module dsfe_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	input  dsfe_pkg::frame_set_t  wr_data,
	output logic                  rd_valid,
	input  logic                  rd_pop,
	output dsfe_pkg::frame_set_t  rd_data
);

	dsfe_pkg::frame_set_t mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ sv/dsfe_back.sv @@
// ----------------------------------------------------------------------------
// dsfe_back
// walks the slots of one frame set, one slot a cycle while the output
// register is free or popped, into that register, which holds the oldest result beat
// ----------------------------------------------------------------------------
module dsfe_back #(
	parameter int unsigned GUARD_SLOTS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frm_valid,
	output logic                  frm_pop,
	input  dsfe_pkg::frame_set_t  frm_data,
	input  logic [9:0]            high_time_one,
	input  logic [9:0]            high_time_zero,
	output logic                  empty,
	input  logic                  pop,
	output dsfe_pkg::out_item_t   result
);

	localparam int unsigned TOTAL     = dsfe_pkg::FRAME_BITS + GUARD_SLOTS;
	localparam logic [5:0]  LAST_SLOT = 6'(TOTAL - 1);

	logic                 busy_q;
	logic [5:0]           slot_q;
	dsfe_pkg::frame_set_t frame_q;
	logic                 out_valid_q;
	dsfe_pkg::out_item_t  out_q;

	logic                 advance;
	logic                 at_last;
	logic                 guard;
	logic [3:0]           bit_idx;
	logic [9:0]           width [dsfe_pkg::NUM_CH];
	dsfe_pkg::out_item_t  slot_res;

	assign advance = busy_q && (!out_valid_q || pop);
	assign at_last = (slot_q == LAST_SLOT);
	assign frm_pop = frm_valid && (!busy_q || (advance && at_last));

	assign guard   = (slot_q[5:4] != 2'b00);
	assign bit_idx = ~slot_q[3:0];

	always_comb begin
		for (int c = 0; c < dsfe_pkg::NUM_CH; c++) begin
			if (guard) begin
				width[c] = 10'd0;
			end else if (frame_q[c][bit_idx]) begin
				width[c] = high_time_one;
			end else begin
				width[c] = high_time_zero;
			end
		end
		slot_res.slot_number = slot_q;
		slot_res.width_ch0   = width[0];
		slot_res.width_ch1   = width[1];
		slot_res.width_ch2   = width[2];
		slot_res.width_ch3   = width[3];
		slot_res.guard_slot  = guard;
		slot_res.last_slot   = at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				busy_q <= frm_valid;
				slot_q <= 6'd0;
			end else if (advance) begin
				if (at_last) begin
					busy_q <= frm_valid;
					slot_q <= 6'd0;
				end else begin
					slot_q <= slot_q + 6'd1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frm_pop) frame_q <= frm_data;
		if (advance) out_q <= slot_res;
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

@@ sv/dshot_four_channel_frame_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// dshot_four_channel_frame_encoder_unit
// four-channel dshot frame encoder: throttle beats in, per-slot pulse
// widths out
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  beat
//  item      in         push / full                four throttles, telemetry bit
//  result    out        empty / pop                slot number, four widths, flags
//  cfg       in         cfg_wr_en (no wait)        register index and value
//
//  every input beat gives 16 + GUARD_SLOTS result beats, one a cycle while the
//  result register is free or popped, so the slot walker sets the sustained rate
//  front stage plus a two-entry frame queue let new beats in while a frame
//  is still being walked; with everything idle an item goes through the front
//  register, a queue entry and the frame register ahead of the result register
//  a held result (empty low, pop low) stalls the slot walker
//  reset clears all control state and loads the pulse widths 205 and 102
// ----------------------------------------------------------------------------
module dshot_four_channel_frame_encoder_unit #(
	parameter int unsigned GUARD_SLOTS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input side
	input  logic                  push,
	output logic                  full,
	input  dsfe_pkg::in_item_t    item,
	// result side
	output logic                  empty,
	input  logic                  pop,
	output dsfe_pkg::out_item_t   result,
	// configuration writes
	input  logic                  cfg_wr_en,
	input  logic [0:0]            cfg_index,
	input  logic [9:0]            cfg_wdata
);

	// pulse width registers
	logic [9:0] high_time_one_q;
	logic [9:0] high_time_zero_q;

	// front to queue
	logic                 frm_valid;
	logic                 frm_ready;
	dsfe_pkg::frame_set_t frm_data;

	// queue to back
	logic                 q_valid;
	logic                 q_pop;
	dsfe_pkg::frame_set_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_time_one_q  <= dsfe_pkg::HIGH_TIME_ONE_RST;
			high_time_zero_q <= dsfe_pkg::HIGH_TIME_ZERO_RST;
		end else if (cfg_wr_en) begin
			case (dsfe_pkg::cfg_reg_t'(cfg_index))
				dsfe_pkg::REG_HIGH_TIME_ONE:  high_time_one_q  <= cfg_wdata;
				dsfe_pkg::REG_HIGH_TIME_ZERO: high_time_zero_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame building
	dsfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm_data  (frm_data)
	);

	// decoupling between frame building and slot walking
	dsfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (frm_valid),
		.wr_ready (frm_ready),
		.wr_data  (frm_data),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_data  (q_data)
	);

	// slot walker and result register
	dsfe_back #(
		.GUARD_SLOTS (GUARD_SLOTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.frm_valid      (q_valid),
		.frm_pop        (q_pop),
		.frm_data       (q_data),
		.high_time_one  (high_time_one_q),
		.high_time_zero (high_time_zero_q),
		.empty          (empty),
		.pop            (pop),
		.result         (result)
	);

endmodule

@@ sv/dsfe_checker.sv @@
// ----------------------------------------------------------------------------
// dsfe_checker
// port-level checks for the frame encoder, bound to the top level
// ----------------------------------------------------------------------------
module dsfe_checker #(
	parameter int unsigned GUARD_SLOTS = 2
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input dsfe_pkg::out_item_t  result
);

	localparam logic [5:0] LAST_SLOT = 6'(dsfe_pkg::FRAME_BITS + GUARD_SLOTS - 1);

	// a waiting beat holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result beat changed while waiting");

	// guard slots carry no pulse
	a_guard_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.guard_slot) |->
		(result.width_ch0 == 10'd0 && result.width_ch1 == 10'd0 &&
		 result.width_ch2 == 10'd0 && result.width_ch3 == 10'd0))
		else $error("guard slot with non-zero width");

	// frame slots sit below slot sixteen, guard slots at or above
	a_guard_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.guard_slot == (result.slot_number >= 6'd16)))
		else $error("guard flag does not match slot number");

	// last flag only on the final slot
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.last_slot == (result.slot_number == LAST_SLOT)))
		else $error("last flag does not match slot number");

	// after the last slot the next beat starts a new frame
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && result.last_slot) ##1 !empty |-> (result.slot_number == 6'd0))
		else $error("new frame does not start at slot zero");

endmodule

bind dshot_four_channel_frame_encoder_unit dsfe_checker #(
	.GUARD_SLOTS (GUARD_SLOTS)
) u_dsfe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

@@ tb/dshot_slot_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dshot_slot_checker
// watches the item, result and configuration channels of the frame encoder,
// works out the slot beats that each accepted item must give and compares
// every result beat against the oldest one still waiting
// ----------------------------------------------------------------------------
module dshot_slot_checker #(
	parameter int unsigned GUARD_SLOTS = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  dsfe_pkg::in_item_t   item,
	input  logic                 empty,
	input  logic                 pop,
	input  dsfe_pkg::out_item_t  result,
	input  logic                 cfg_wr_en,
	input  logic [0:0]           cfg_index,
	input  logic [9:0]           cfg_wdata,
	output int unsigned          slot_errors,
	output int unsigned          slots_pending,
	output int unsigned          slots_checked
);
	import dsfe_pkg::*;

	localparam int unsigned SLOTS_PER_FRAME = FRAME_BITS + GUARD_SLOTS;
	localparam logic [9:0]  THROTTLE_CEIL   = 10'd1000;
	localparam logic [10:0] DSHOT_OFFSET    = 11'd47;

	logic [9:0]  width_one;
	logic [9:0]  width_zero;
	out_item_t   expected_slots[$];
	int unsigned error_total;
	int unsigned compared_total;

	// clip to full throttle, 2t+47, telemetry bit below, nibble xor checksum last
	function automatic logic [15:0] dshot_frame_word(input logic [9:0] throttle,
		input logic telem);
		logic [9:0]  clipped;
		logic [10:0] code;
		logic [11:0] body;
		logic [3:0]  crc;
		clipped = (throttle > THROTTLE_CEIL) ? THROTTLE_CEIL : throttle;
		code    = 11'(clipped) * 11'd2 + DSHOT_OFFSET;
		body    = {code, telem};
		crc     = body[11:8] ^ body[7:4] ^ body[3:0];
		return {body, crc};
	endfunction

	task automatic predict_slots(input in_item_t beat);
		logic [15:0] frames [NUM_CH];
		logic [9:0]  widths [NUM_CH];
		out_item_t   slot;
		frames[0] = dshot_frame_word(beat.throttle_ch0, beat.telemetry_request);
		frames[1] = dshot_frame_word(beat.throttle_ch1, beat.telemetry_request);
		frames[2] = dshot_frame_word(beat.throttle_ch2, beat.telemetry_request);
		frames[3] = dshot_frame_word(beat.throttle_ch3, beat.telemetry_request);
		for (int unsigned s = 0; s < SLOTS_PER_FRAME; s++) begin
			for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
				if (s >= FRAME_BITS)
					widths[ch] = '0;
				else
					widths[ch] = frames[ch][FRAME_BITS-1-s] ? width_one : width_zero;
			end
			slot.slot_number = 6'(s);
			slot.width_ch0   = widths[0];
			slot.width_ch1   = widths[1];
			slot.width_ch2   = widths[2];
			slot.width_ch3   = widths[3];
			slot.guard_slot  = (s >= FRAME_BITS);
			slot.last_slot   = (s == SLOTS_PER_FRAME - 1);
			expected_slots.push_back(slot);
		end
	endtask

	task automatic check_field(input string field_name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			error_total++;
			$display("%0t: %s mismatch, expected %0d, got %0d",
				$time, field_name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			width_one      = HIGH_TIME_ONE_RST;
			width_zero     = HIGH_TIME_ZERO_RST;
			error_total    = 0;
			compared_total = 0;
			expected_slots.delete();
		end else begin
			if (!empty && pop) begin
				if (expected_slots.size() == 0) begin
					error_total++;
					$display("%0t: unexpected result beat, expected none, got %h",
						$time, result);
				end else begin
					want = expected_slots.pop_front();
					compared_total++;
					check_field("slot_number", want.slot_number, result.slot_number);
					check_field("width_ch0", want.width_ch0, result.width_ch0);
					check_field("width_ch1", want.width_ch1, result.width_ch1);
					check_field("width_ch2", want.width_ch2, result.width_ch2);
					check_field("width_ch3", want.width_ch3, result.width_ch3);
					check_field("guard_slot", want.guard_slot, result.guard_slot);
					check_field("last_slot", want.last_slot, result.last_slot);
				end
			end
			if (push && !full)
				predict_slots(item);
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_HIGH_TIME_ONE:  width_one  = cfg_wdata;
					REG_HIGH_TIME_ZERO: width_zero = cfg_wdata;
					default: ;
				endcase
			end
		end
		slot_errors   <= error_total;
		slots_pending <= expected_slots.size();
		slots_checked <= compared_total;
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives frame requests and pulse-width settings into the four-channel dshot
// encoder with random gaps on both sides; a side checker predicts the slots
// ----------------------------------------------------------------------------
module testbench;
	import dsfe_pkg::*;

	localparam int unsigned GUARD_SLOTS      = 2;
	localparam int unsigned QUIET_LIMIT      = 3000;
	localparam int unsigned HOLD_OFF_CYCLES  = 300;
	localparam int unsigned RANDOM_PER_PHASE = 25;
	localparam int unsigned PRESSURE_BURST   = 10;
	localparam int unsigned TAIL_CYCLES      = 40;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	in_item_t    item      = '0;
	logic        empty;
	logic        pop       = 1'b0;
	out_item_t   result;
	logic        cfg_wr_en = 1'b0;
	logic [0:0]  cfg_index = REG_HIGH_TIME_ONE;
	logic [9:0]  cfg_wdata = '0;

	int unsigned slot_errors;
	int unsigned slots_pending;
	int unsigned slots_checked;
	int unsigned frames_sent    = 0;
	int unsigned settings_used  = 1;
	int unsigned quiet_cycles   = 0;

	// handshake between the stimulus and the receiver for the long hold-off
	bit          hold_off_req    = 1'b0;
	bit          hold_off_active = 1'b0;

	dshot_four_channel_frame_encoder_unit #(
		.GUARD_SLOTS (GUARD_SLOTS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	dshot_slot_checker #(
		.GUARD_SLOTS (GUARD_SLOTS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.item          (item),
		.empty         (empty),
		.pop           (pop),
		.result        (result),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.slot_errors   (slot_errors),
		.slots_pending (slots_pending),
		.slots_checked (slots_checked)
	);

	// 20 ns clock
	initial begin
		forever #10 clk = ~clk;
	end

	// watchdog: any beat on any channel counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_wr_en) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// mostly in range, some saturating, some anywhere in the field, some at the ends
	function automatic logic [9:0] pick_throttle();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 10'($urandom_range(1001, 1023));
		if (r == 1)
			return 10'($urandom_range(0, 1023));
		if (r == 2)
			return $urandom_range(0, 1) ? 10'd1000 : 10'd0;
		return 10'($urandom_range(0, 1000));
	endfunction

	function automatic in_item_t random_request();
		in_item_t beat;
		beat.throttle_ch0      = pick_throttle();
		beat.throttle_ch1      = pick_throttle();
		beat.throttle_ch2      = pick_throttle();
		beat.throttle_ch3      = pick_throttle();
		beat.telemetry_request = 1'($urandom_range(0, 1));
		return beat;
	endfunction

	// mostly none or short, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		return $urandom_range(10, 50);
	endfunction

	// hold push high until the encoder takes the beat
	task automatic offer_frame_request(input in_item_t beat);
		push <= 1'b1;
		item <= beat;
		do @(posedge clk); while (full);
		frames_sent++;
	endtask

	task automatic idle_sender();
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// every expected slot out before the widths may change
	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (slots_pending != 0);
	endtask

	task automatic write_pulse_widths(input logic [9:0] one_ticks,
		input logic [9:0] zero_ticks);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_HIGH_TIME_ONE;
		cfg_wdata <= one_ticks;
		@(posedge clk);
		cfg_index <= REG_HIGH_TIME_ZERO;
		cfg_wdata <= zero_ticks;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic run_random_requests(input int unsigned count);
		repeat (count) begin
			offer_frame_request(random_request());
			idle_sender();
		end
	endtask

	// receiver: random pop gaps and bursts, plus the long hold-off on request
	initial begin : receiver
		int unsigned gap;
		int unsigned burst;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_active = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req    = 1'b0;
				hold_off_active = 1'b0;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				// a few long stretches with pop held high throughout
				burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
					: $urandom_range(1, 24);
				pop <= 1'b1;
				repeat (burst) @(posedge clk);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		in_item_t directed[$];

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under the reset widths: field ends, saturation, bit patterns
		directed.push_back(in_item_t'{10'd0, 10'd0, 10'd0, 10'd0, 1'b0});
		directed.push_back(in_item_t'{10'd0, 10'd0, 10'd0, 10'd0, 1'b1});
		directed.push_back(in_item_t'{10'd1000, 10'd1000, 10'd1000, 10'd1000, 1'b0});
		directed.push_back(in_item_t'{10'd1000, 10'd1000, 10'd1000, 10'd1000, 1'b1});
		directed.push_back(in_item_t'{10'd1001, 10'd1023, 10'd999, 10'd1, 1'b0});
		directed.push_back(in_item_t'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1});
		directed.push_back(in_item_t'{10'h2AA, 10'h155, 10'h3FF, 10'h200, 1'b0});
		directed.push_back(in_item_t'{10'h155, 10'h2AA, 10'h001, 10'h3E8, 1'b1});
		directed.push_back(in_item_t'{10'd1, 10'd2, 10'd3, 10'd4, 1'b1});
		directed.push_back(in_item_t'{10'd500, 10'd0, 10'd1000, 10'd1023, 1'b0});
		foreach (directed[i]) begin
			offer_frame_request(directed[i]);
			idle_sender();
		end

		// widths at the extremes, one way round
		drain_results();
		write_pulse_widths(10'd1023, 10'd0);
		run_random_requests(RANDOM_PER_PHASE);

		// the other way round, with the receiver holding off mid-phase
		drain_results();
		write_pulse_widths(10'd0, 10'd1023);
		run_random_requests(RANDOM_PER_PHASE / 2);
		push <= 1'b0;
		hold_off_req = 1'b1;
		while (!hold_off_active) @(posedge clk);
		// back-to-back beats so the frame queue fills and full has to rise
		repeat (PRESSURE_BURST) offer_frame_request(random_request());
		idle_sender();
		run_random_requests(RANDOM_PER_PHASE / 2);

		// arbitrary widths
		drain_results();
		write_pulse_widths(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
		run_random_requests(RANDOM_PER_PHASE);

		// alternating bit patterns in the widths
		drain_results();
		write_pulse_widths(10'h155, 10'h2AA);
		run_random_requests(RANDOM_PER_PHASE);

		drain_results();
		// stray beats after the last expected one still count against the run
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d frame requests over %0d pulse-width settings,",
			frames_sent, settings_used);
		$display("saturation and a long receiver stall included; %0d slot beats compared, %0d field mismatches",
			slots_checked, slot_errors);
		if (slot_errors == 0 && slots_pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
